[rtl/gme_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gme_pkg;

  // Field widths fixed by the item format
  localparam int KIND_W    = 3;
  localparam int INDEX_W   = 12;
  localparam int VALUE_W   = 9;
  localparam int PIX_W     = 8;
  localparam int SIDE_W    = 7;

  localparam int MAX_SIDE_DEF = 64;
  localparam int SIDE_RESET   = 64;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    K_LOAD      = 3'd0,
    K_ADD       = 3'd1,
    K_SUB       = 3'd2,
    K_DIAG      = 3'd3,
    K_TRANSPOSE = 3'd4,
    K_BINARIZE  = 3'd5,
    K_MINMAX    = 3'd6,
    K_READ      = 3'd7
  } kind_t;

  // Pixel unit operations
  typedef enum logic [1:0] {
    ALU_LOAD = 2'd0,
    ALU_ADD  = 2'd1,
    ALU_SUB  = 2'd2,
    ALU_BIN  = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    track_en;
    logic    track_first;
  } alu_ctl_t;

  typedef struct packed {
    kind_t               kind;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_diagonal;
    logic [PIX_W-1:0] largest;
    logic [PIX_W-1:0] smallest;
  } out_t;

endpackage

`default_nettype wire

[rtl/grayscale_matrix_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload           Direction
// input     start / busy           in_data (in_t)    in
// result    out_valid (strobe)     out_data (out_t)  out
// config    cfg_valid / cfg_ready  cfg_data (side)   in
//
// Load, add, subtract and read go through a store read, then an update or return;
// out-of-range index, min/max and trivial transpose answer the cycle after accept.
// Diagonal test and binarize walk the whole image (one store read port, one pixel
// a cycle); transpose fetches each swapped pair, then writes both back (TA, TB, TW1, TW2).
// Reset (rst_n low, synchronous) clears the sequencer and tracked min/max and sets
// side to 64; the pixel store is not cleared. Results cannot be stalled.

module grayscale_matrix_engine #(
  parameter int MAX_SIDE = gme_pkg::MAX_SIDE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire gme_pkg::in_t               in_data,
  output logic                            busy,
  output logic                            out_valid,
  output gme_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [gme_pkg::SIDE_W-1:0] cfg_data
);

  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int NW       = $clog2(DEPTH + 1);
  localparam int SIDE_RST = (gme_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE : gme_pkg::SIDE_RESET;
  localparam int N_RST    = SIDE_RST * SIDE_RST;

  logic [SW-1:0]                   side_r, side_nxt;
  logic [NW-1:0]                   npix_r, npix_nxt;
  logic [8:0]                      cfg_ext;
  logic [2*SW-1:0]                 side_sq;

  logic                            rd_en, wr_en;
  logic [AW-1:0]                   rd_addr, wr_addr;
  logic [gme_pkg::PIX_W-1:0]       rd_data, wr_data;
  gme_pkg::alu_ctl_t               alu_ctl;
  logic [gme_pkg::VALUE_W-1:0]     alu_val;
  logic [gme_pkg::PIX_W-1:0]       alu_res, largest, smallest;
  logic [gme_pkg::PIX_W-1:0]       res_pixel;
  logic                            res_diag;

  // Clamp side to 1..MAX_SIDE and precompute pixel count
  assign cfg_ext = {2'b00, cfg_data};
  always_comb begin
    if (cfg_ext == 9'd0) begin
      side_nxt = SW'(1);
    end else if (cfg_ext > 9'(MAX_SIDE)) begin
      side_nxt = SW'(MAX_SIDE);
    end else begin
      side_nxt = SW'(cfg_ext);
    end
    side_sq  = side_nxt * side_nxt;
    npix_nxt = NW'(side_sq);
  end

  // Accept a side write only with no item in flight or being accepted
  assign cfg_ready = !busy && !start && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SW'(SIDE_RST);
      npix_r <= NW'(N_RST);
    end else if (cfg_valid && cfg_ready) begin
      side_r <= side_nxt;
      npix_r <= npix_nxt;
    end
  end

  gme_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gme_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (alu_ctl),
    .cur      (rd_data),
    .val      (alu_val),
    .res      (alu_res),
    .largest  (largest),
    .smallest (smallest)
  );

  gme_ctrl #(
    .SW (SW),
    .NW (NW),
    .AW (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .side_eff  (side_r),
    .n_pix     (npix_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .alu_ctl   (alu_ctl),
    .alu_val   (alu_val),
    .alu_res   (alu_res),
    .out_valid (out_valid),
    .out_pixel (res_pixel),
    .out_diag  (res_diag)
  );

  // Assemble the result beat
  assign out_data = '{pixel: res_pixel, is_diagonal: res_diag,
                      largest: largest, smallest: smallest};

endmodule

`default_nettype wire

[rtl/gme_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module gme_store #(
  parameter int DEPTH = gme_pkg::MAX_SIDE_DEF * gme_pkg::MAX_SIDE_DEF,
  parameter int AW    = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [gme_pkg::PIX_W-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [gme_pkg::PIX_W-1:0] wr_data
);

  logic [gme_pkg::PIX_W-1:0] mem [DEPTH];
  logic [gme_pkg::PIX_W-1:0] rd_data_r;

  // Write one pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/gme_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module gme_alu (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gme_pkg::alu_ctl_t           ctl,
  input  wire logic [gme_pkg::PIX_W-1:0]   cur,
  input  wire logic [gme_pkg::VALUE_W-1:0] val,
  output logic      [gme_pkg::PIX_W-1:0]   res,
  output logic      [gme_pkg::PIX_W-1:0]   largest,
  output logic      [gme_pkg::PIX_W-1:0]   smallest
);

  logic [gme_pkg::VALUE_W:0]   sum;
  logic [gme_pkg::VALUE_W-1:0] cur_ext;
  logic [gme_pkg::PIX_W-1:0]   max_r, max_nxt;
  logic [gme_pkg::PIX_W-1:0]   min_r, min_nxt;

  assign cur_ext = {1'b0, cur};
  assign sum     = {1'b0, cur_ext} + {1'b0, val};

  // Saturating pixel arithmetic and threshold
  always_comb begin
    case (ctl.op)
      gme_pkg::ALU_LOAD: begin
        res = (val > {1'b0, gme_pkg::PIX_MAX}) ? gme_pkg::PIX_MAX : val[gme_pkg::PIX_W-1:0];
      end
      gme_pkg::ALU_ADD: begin
        res = (sum > {2'b00, gme_pkg::PIX_MAX}) ? gme_pkg::PIX_MAX : sum[gme_pkg::PIX_W-1:0];
      end
      gme_pkg::ALU_SUB: begin
        res = (cur_ext > val) ? gme_pkg::PIX_W'(cur_ext - val) : '0;
      end
      gme_pkg::ALU_BIN: begin
        res = (cur_ext >= val) ? gme_pkg::PIX_MAX : '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Restart tracking at the first pixel, else widen
  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    if (ctl.track_en) begin
      if (ctl.track_first) begin
        max_nxt = res;
        min_nxt = res;
      end else if (res > max_r) begin
        max_nxt = res;
      end else if (res < min_r) begin
        min_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      min_r <= '0;
    end else begin
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  assign largest  = max_r;
  assign smallest = min_r;

endmodule

`default_nettype wire

[rtl/gme_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module gme_ctrl #(
  parameter int SW = 7,
  parameter int NW = 13,
  parameter int AW = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire gme_pkg::in_t                in_data,
  output logic                             busy,
  input  wire logic [SW-1:0]               side_eff,
  input  wire logic [NW-1:0]               n_pix,
  output logic                             rd_en,
  output logic [AW-1:0]                    rd_addr,
  input  wire logic [gme_pkg::PIX_W-1:0]   rd_data,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [gme_pkg::PIX_W-1:0]        wr_data,
  output gme_pkg::alu_ctl_t                alu_ctl,
  output logic [gme_pkg::VALUE_W-1:0]      alu_val,
  input  wire logic [gme_pkg::PIX_W-1:0]   alu_res,
  output logic                             out_valid,
  output logic [gme_pkg::PIX_W-1:0]        out_pixel,
  output logic                             out_diag
);

  localparam int CW = (NW > gme_pkg::INDEX_W) ? NW : gme_pkg::INDEX_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PE   = 7'b0000010,
    ST_WALK = 7'b0000100,
    ST_TA   = 7'b0001000,
    ST_TB   = 7'b0010000,
    ST_TW1  = 7'b0100000,
    ST_TW2  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  gme_pkg::kind_t                  kind_r, kind_nxt;
  logic [gme_pkg::VALUE_W-1:0]     val_r, val_nxt;
  logic [AW-1:0]                   idx_r, idx_nxt;
  logic [AW-1:0]                   pend_r, pend_nxt;
  logic                            pend_off_r, pend_off_nxt;
  logic                            pend_last_r, pend_last_nxt;
  logic [SW-1:0]                   row_r, row_nxt;
  logic [SW-1:0]                   col_r, col_nxt;
  logic                            dacc_r, dacc_nxt;
  logic [AW-1:0]                   d_r, d_nxt;
  logic [AW-1:0]                   a_r, a_nxt;
  logic [AW-1:0]                   b_r, b_nxt;
  logic [gme_pkg::PIX_W-1:0]       tmp_r, tmp_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [gme_pkg::PIX_W-1:0]       pixel_r, pixel_nxt;
  logic                            isdiag_r, isdiag_nxt;

  logic [CW-1:0]                   idx_ext;
  logic                            in_range;
  logic [SW-1:0]                   side_m1, side_m2;
  logic [AW-1:0]                   side_a;
  logic [AW-1:0]                   pend_inc;
  logic [AW-1:0]                   d_step;
  logic [SW-1:0]                   row_n, col_n;
  logic                            dacc_now;

  assign idx_ext  = CW'(in_data.index);
  assign in_range = idx_ext < CW'(n_pix);
  assign side_m1  = side_eff - SW'(1);
  assign side_m2  = side_eff - SW'(2);
  assign side_a   = AW'(side_eff);
  assign pend_inc = pend_r + AW'(1);
  assign d_step   = d_r + side_a + AW'(1);
  assign dacc_now = dacc_r & ~(pend_off_r & (rd_data != '0));

  // Raster position after the pending pixel
  always_comb begin
    if (col_r == side_m1) begin
      col_n = '0;
      row_n = row_r + SW'(1);
    end else begin
      col_n = col_r + SW'(1);
      row_n = row_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_off_nxt  = pend_off_r;
    pend_last_nxt = pend_last_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    dacc_nxt      = dacc_r;
    d_nxt         = d_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = 1'b0;
    pixel_nxt     = pixel_r;
    isdiag_nxt    = isdiag_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = alu_res;
    alu_ctl       = '{op: gme_pkg::ALU_LOAD, track_en: 1'b0, track_first: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt = in_data.kind;
          val_nxt  = in_data.value;
          case (in_data.kind)
            gme_pkg::K_LOAD, gme_pkg::K_ADD, gme_pkg::K_SUB, gme_pkg::K_READ: begin
              if (in_range) begin
                rd_en     = 1'b1;
                rd_addr   = idx_ext[AW-1:0];
                idx_nxt   = idx_ext[AW-1:0];
                state_nxt = ST_PE;
              end else begin
                out_valid_nxt = 1'b1;
                pixel_nxt     = '0;
                isdiag_nxt    = 1'b0;
              end
            end
            gme_pkg::K_DIAG, gme_pkg::K_BINARIZE: begin
              rd_en         = 1'b1;
              rd_addr       = '0;
              pend_nxt      = '0;
              pend_off_nxt  = 1'b0;
              pend_last_nxt = (n_pix == NW'(1));
              row_nxt       = '0;
              col_nxt       = '0;
              dacc_nxt      = 1'b1;
              state_nxt     = ST_WALK;
            end
            gme_pkg::K_TRANSPOSE: begin
              if (side_eff > SW'(1)) begin
                row_nxt   = '0;
                col_nxt   = SW'(1);
                d_nxt     = '0;
                a_nxt     = AW'(1);
                b_nxt     = side_a;
                state_nxt = ST_TA;
              end else begin
                out_valid_nxt = 1'b1;
                pixel_nxt     = '0;
                isdiag_nxt    = 1'b0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              pixel_nxt     = '0;
              isdiag_nxt    = 1'b0;
            end
          endcase
        end
      end

      // Single pixel: read data is back, update or return it
      ST_PE: begin
        out_valid_nxt = 1'b1;
        isdiag_nxt    = 1'b0;
        state_nxt     = ST_IDLE;
        if (kind_r == gme_pkg::K_READ) begin
          pixel_nxt = rd_data;
        end else begin
          case (kind_r)
            gme_pkg::K_ADD: alu_ctl.op = gme_pkg::ALU_ADD;
            gme_pkg::K_SUB: alu_ctl.op = gme_pkg::ALU_SUB;
            default:        alu_ctl.op = gme_pkg::ALU_LOAD;
          endcase
          alu_ctl.track_en    = 1'b1;
          alu_ctl.track_first = (idx_r == '0);
          wr_en     = 1'b1;
          wr_addr   = idx_r;
          pixel_nxt = alu_res;
        end
      end

      // Whole-image walk: check or rewrite the pending pixel, issue the next
      ST_WALK: begin
        if (kind_r == gme_pkg::K_BINARIZE) begin
          alu_ctl.op          = gme_pkg::ALU_BIN;
          alu_ctl.track_en    = 1'b1;
          alu_ctl.track_first = (pend_r == '0);
          wr_en               = 1'b1;
          wr_addr             = pend_r;
        end
        dacc_nxt = dacc_now;
        if (pend_last_r) begin
          out_valid_nxt = 1'b1;
          pixel_nxt     = '0;
          isdiag_nxt    = (kind_r == gme_pkg::K_DIAG) ? dacc_now : 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = pend_inc;
          pend_nxt      = pend_inc;
          pend_off_nxt  = (row_n != col_n);
          pend_last_nxt = (NW'(pend_inc) == (n_pix - NW'(1)));
          row_nxt       = row_n;
          col_nxt       = col_n;
        end
      end

      // Transpose: fetch upper pixel
      ST_TA: begin
        rd_en     = 1'b1;
        rd_addr   = a_r;
        state_nxt = ST_TB;
      end

      // Hold upper pixel, fetch its mirror
      ST_TB: begin
        tmp_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = b_r;
        state_nxt = ST_TW1;
      end

      ST_TW1: begin
        wr_en     = 1'b1;
        wr_addr   = a_r;
        wr_data   = rd_data;
        state_nxt = ST_TW2;
      end

      // Write mirror, advance to the next pair
      ST_TW2: begin
        wr_en   = 1'b1;
        wr_addr = b_r;
        wr_data = tmp_r;
        if (col_r == side_m1) begin
          if (row_r == side_m2) begin
            out_valid_nxt = 1'b1;
            pixel_nxt     = '0;
            isdiag_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            row_nxt   = row_r + SW'(1);
            col_nxt   = row_r + SW'(2);
            d_nxt     = d_step;
            a_nxt     = d_step + AW'(1);
            b_nxt     = d_step + side_a;
            state_nxt = ST_TA;
          end
        end else begin
          col_nxt   = col_r + SW'(1);
          a_nxt     = a_r + AW'(1);
          b_nxt     = b_r + side_a;
          state_nxt = ST_TA;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    pend_r      <= pend_nxt;
    pend_off_r  <= pend_off_nxt;
    pend_last_r <= pend_last_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    dacc_r      <= dacc_nxt;
    d_r         <= d_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    tmp_r       <= tmp_nxt;
    pixel_r     <= pixel_nxt;
    isdiag_r    <= isdiag_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign alu_val   = val_r;
  assign out_valid = out_valid_r;
  assign out_pixel = pixel_r;
  assign out_diag  = isdiag_r;

  // Result strobes only once the sequencer is back at rest
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // No store writes from rest
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("store write while idle");

  // Writes stay inside the active image
  a_write_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (NW'(wr_addr) < n_pix))
    else $error("store write outside image");

  // A walk item always keeps the sequencer busy in the cycle after it is accepted
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind == gme_pkg::K_DIAG ||
     in_data.kind == gme_pkg::K_BINARIZE)) |=> busy)
    else $error("walk did not start");

endmodule

`default_nettype wire

[verif/gme_checker.sv]
`timescale 1ns / 1ps

// Watches the item, result and side-register channels of the grayscale engine,
// keeps a shadow image with its tracked extremes, and scores every result beat.
module gme_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire gme_pkg::in_t               in_data,
  input  wire logic                       out_valid,
  input  wire gme_pkg::out_t              out_data,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [gme_pkg::SIDE_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              backlog
);

  localparam int DEPTH      = gme_pkg::MAX_SIDE_DEF * gme_pkg::MAX_SIDE_DEF;
  localparam int MAX_REPORT = 10;

  logic [gme_pkg::PIX_W-1:0]  shadow_image [DEPTH];
  logic [gme_pkg::PIX_W-1:0]  brightest;
  logic [gme_pkg::PIX_W-1:0]  darkest;
  logic [gme_pkg::SIDE_W-1:0] side_reg;
  gme_pkg::out_t              predicted_beats [$];

  // Clamp the programmed side into the supported range
  function automatic int active_side();
    if (side_reg == '0) return 1;
    if (side_reg > gme_pkg::MAX_SIDE_DEF) return gme_pkg::MAX_SIDE_DEF;
    return int'(side_reg);
  endfunction

  // Restart the extremes at address zero, otherwise widen them
  function automatic void track_pixel(input int pos, input logic [gme_pkg::PIX_W-1:0] p);
    if (pos == 0) begin
      brightest = p;
      darkest   = p;
    end else if (p > brightest) begin
      brightest = p;
    end else if (p < darkest) begin
      darkest = p;
    end
  endfunction

  // Apply one item to the shadow image and return the beat it should produce
  function automatic gme_pkg::out_t image_step(input gme_pkg::in_t beat);
    int                        s;
    int                        n;
    int                        cur;
    logic [gme_pkg::PIX_W-1:0] tmp;
    gme_pkg::out_t             res;
    s   = active_side();
    n   = s * s;
    res = '0;
    case (beat.kind)
      gme_pkg::K_LOAD, gme_pkg::K_ADD, gme_pkg::K_SUB: begin
        if (beat.index < n) begin
          cur = shadow_image[beat.index];
          if (beat.kind == gme_pkg::K_LOAD) begin
            cur = beat.value;
          end else if (beat.kind == gme_pkg::K_ADD) begin
            cur = cur + beat.value;
          end else begin
            cur = (cur > beat.value) ? cur - beat.value : 0;
          end
          if (cur > gme_pkg::PIX_MAX) cur = gme_pkg::PIX_MAX;
          shadow_image[beat.index] = cur[gme_pkg::PIX_W-1:0];
          track_pixel(beat.index, cur[gme_pkg::PIX_W-1:0]);
          res.pixel = cur[gme_pkg::PIX_W-1:0];
        end
      end
      gme_pkg::K_DIAG: begin
        res.is_diagonal = 1'b1;
        for (int i = 0; i < n; i++) begin
          if ((i % (s + 1)) != 0 && shadow_image[i] != '0) begin
            res.is_diagonal = 1'b0;
            break;
          end
        end
      end
      gme_pkg::K_TRANSPOSE: begin
        for (int r = 0; r < s; r++) begin
          for (int c = r + 1; c < s; c++) begin
            tmp                      = shadow_image[r * s + c];
            shadow_image[r * s + c]  = shadow_image[c * s + r];
            shadow_image[c * s + r]  = tmp;
          end
        end
      end
      gme_pkg::K_BINARIZE: begin
        for (int i = 0; i < n; i++) begin
          tmp = ({1'b0, shadow_image[i]} >= beat.value) ? gme_pkg::PIX_MAX : '0;
          shadow_image[i] = tmp;
          track_pixel(i, tmp);
        end
      end
      gme_pkg::K_READ: begin
        if (beat.index < n) res.pixel = shadow_image[beat.index];
      end
      default: begin
      end
    endcase
    res.largest  = brightest;
    res.smallest = darkest;
    return res;
  endfunction

  // Register writes first, then the result beat, then the newly accepted item
  always @(posedge clk) begin : watch
    gme_pkg::out_t want;
    logic          bad;
    if (!rst_n) begin
      side_reg       = gme_pkg::SIDE_W'(gme_pkg::SIDE_RESET);
      brightest      = '0;
      darkest        = '0;
      mismatch_count = 0;
      predicted_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) side_reg = cfg_data;

      if (out_valid) begin
        if (predicted_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT)
            $display("%0t: result beat with nothing outstanding: %s%0d %s%0b %s%0d %s%0d",
                     $realtime, "pixel=", out_data.pixel, "diag=", out_data.is_diagonal,
                     "max=", out_data.largest, "min=", out_data.smallest);
        end else begin
          want = predicted_beats.pop_front();
          bad  = (out_data.pixel !== want.pixel) ||
                 (out_data.is_diagonal !== want.is_diagonal) ||
                 (out_data.largest !== want.largest) ||
                 (out_data.smallest !== want.smallest);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT)
              $display({"%0t: result mismatch: expected pixel=%0d diag=%0b max=%0d min=%0d,",
                        " got pixel=%0d diag=%0b max=%0d min=%0d"},
                       $realtime, want.pixel, want.is_diagonal, want.largest, want.smallest,
                       out_data.pixel, out_data.is_diagonal, out_data.largest,
                       out_data.smallest);
          end
        end
      end

      if (start && !busy) predicted_beats.push_back(image_step(in_data));
    end
    backlog = predicted_beats.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH       = gme_pkg::MAX_SIDE_DEF * gme_pkg::MAX_SIDE_DEF;
  localparam int ITEM_TARGET = 1700;
  localparam int QUIET_LIMIT = 40000;
  localparam int SIDE_TOP    = (1 << gme_pkg::SIDE_W) - 1;
  localparam int FILL_SIDE   = 20;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  gme_pkg::in_t               in_data   = '0;
  logic                       cfg_valid = 1'b0;
  logic [gme_pkg::SIDE_W-1:0] cfg_data  = '0;
  logic                       busy;
  logic                       out_valid;
  logic                       cfg_ready;
  gme_pkg::out_t              out_data;
  int                         mismatch_count;
  int                         backlog;
  int                         quiet_cycles = 0;

  // Stimulus bookkeeping: which addresses hold a defined pixel, and the side in effect
  bit written [DEPTH];
  int cur_side    = gme_pkg::SIDE_RESET;
  bit gaps_on     = 1'b1;
  int item_count  = 0;

  always #2 clk = ~clk;

  grayscale_matrix_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gme_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .backlog        (backlog)
  );

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one item, hold it until accepted; start stays high for a following item
  task automatic push_item(input gme_pkg::kind_t k, input int idx, input int val);
    gme_pkg::in_t it;
    bit           fire;
    it.kind  = k;
    it.index = idx[gme_pkg::INDEX_W-1:0];
    it.value = val[gme_pkg::VALUE_W-1:0];
    while (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      fire = !busy;
      @(posedge clk);
    end while (!fire);
    if (k inside {gme_pkg::K_LOAD, gme_pkg::K_ADD, gme_pkg::K_SUB} &&
        idx < cur_side * cur_side) written[idx] = 1'b1;
    item_count++;
  endtask

  // Drop start and wait until every result is back
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    repeat (4) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_side(input int s);
    bit fire;
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= s[gme_pkg::SIDE_W-1:0];
    do begin
      @(negedge clk);
      fire = cfg_ready;
      @(posedge clk);
    end while (!fire);
    cfg_valid <= 1'b0;
    cur_side = (s == 0) ? 1 : (s > gme_pkg::MAX_SIDE_DEF) ? gme_pkg::MAX_SIDE_DEF : s;
  endtask

  // Zero the off-diagonal pixels, then test, flip, sometimes add to pixel 1, and test again
  task automatic build_diagonal();
    int n;
    n = cur_side * cur_side;
    for (int i = 0; i < n; i++)
      push_item(gme_pkg::K_LOAD, i, ((i % (cur_side + 1)) == 0) ? $urandom_range(511) : 0);
    push_item(gme_pkg::K_DIAG, $urandom_range(DEPTH - 1), $urandom_range(511));
    push_item(gme_pkg::K_TRANSPOSE, $urandom_range(DEPTH - 1), $urandom_range(511));
    if (cur_side > 1 && $urandom_range(1) == 1)
      push_item(gme_pkg::K_ADD, 1, $urandom_range(1, 511));
    push_item(gme_pkg::K_DIAG, $urandom_range(DEPTH - 1), $urandom_range(511));
  endtask

  // One random item; whole-image walks are rationed by the caller's budget
  task automatic random_item(inout int walks_left);
    int             n;
    int             idx;
    int             val;
    int             pick;
    gme_pkg::kind_t k;
    n    = cur_side * cur_side;
    pick = $urandom_range(99);
    if (pick < 25)      k = gme_pkg::K_LOAD;
    else if (pick < 40) k = gme_pkg::K_ADD;
    else if (pick < 55) k = gme_pkg::K_SUB;
    else if (pick < 68) k = gme_pkg::K_READ;
    else if (pick < 76) k = gme_pkg::K_MINMAX;
    else if (pick < 84) k = gme_pkg::K_DIAG;
    else if (pick < 92) k = gme_pkg::K_TRANSPOSE;
    else                k = gme_pkg::K_BINARIZE;
    if (k inside {gme_pkg::K_DIAG, gme_pkg::K_TRANSPOSE, gme_pkg::K_BINARIZE}) begin
      if (walks_left == 0) k = gme_pkg::K_MINMAX;
      else walks_left--;
    end
    pick = $urandom_range(99);
    if (pick < 10)      idx = 0;
    else if (pick < 80) idx = $urandom_range(n - 1);
    else                idx = $urandom_range(DEPTH - 1);
    // never touch a pixel that holds nothing defined yet
    if (k inside {gme_pkg::K_ADD, gme_pkg::K_SUB, gme_pkg::K_READ} && idx < n && !written[idx])
      k = gme_pkg::K_LOAD;
    pick = $urandom_range(99);
    if (pick < 40)      val = $urandom_range(20);
    else if (pick < 50) val = $urandom_range(254, 257);
    else                val = $urandom_range(511);
    push_item(k, idx, val);
  endtask

  initial begin
    int phase;
    int pick;
    int s;
    int n;
    int walks_left;
    int len;
    bit full;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2x2 image through saturation, clamping, diagonal, transpose, binarize
    write_side(2);
    push_item(gme_pkg::K_LOAD, 0, 256);
    push_item(gme_pkg::K_LOAD, 1, 0);
    push_item(gme_pkg::K_LOAD, 2, 0);
    push_item(gme_pkg::K_LOAD, 3, 7);
    push_item(gme_pkg::K_DIAG, 0, 0);
    push_item(gme_pkg::K_ADD, 1, 256);
    push_item(gme_pkg::K_DIAG, DEPTH - 1, 511);
    push_item(gme_pkg::K_SUB, 3, 511);
    push_item(gme_pkg::K_ADD, 2, 5);
    push_item(gme_pkg::K_TRANSPOSE, 0, 0);
    push_item(gme_pkg::K_READ, 1, 0);
    push_item(gme_pkg::K_READ, 2, 511);
    push_item(gme_pkg::K_MINMAX, DEPTH - 1, 511);
    push_item(gme_pkg::K_LOAD, DEPTH - 1, 9);
    push_item(gme_pkg::K_READ, 4, 0);
    push_item(gme_pkg::K_SUB, 4, 1);
    push_item(gme_pkg::K_BINARIZE, 0, 5);
    push_item(gme_pkg::K_BINARIZE, 0, 256);
    push_item(gme_pkg::K_BINARIZE, 0, 0);
    push_item(gme_pkg::K_MINMAX, 0, 0);
    push_item(gme_pkg::K_LOAD, 0, 0);
    push_item(gme_pkg::K_ADD, 0, 300);
    // Side of zero behaves as one
    write_side(0);
    push_item(gme_pkg::K_DIAG, 0, 0);
    push_item(gme_pkg::K_TRANSPOSE, 0, 0);
    push_item(gme_pkg::K_READ, 1, 0);

    // Random phases: new side, fill undefined pixels of small images, then mixed traffic
    item_count = 0;
    phase      = 0;
    while (item_count < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (phase == 4)       s = gme_pkg::MAX_SIDE_DEF;
      else if (phase == 9)  s = SIDE_TOP;
      else if (phase == 12) s = 1;
      else if (pick < 8)    s = $urandom_range(1);
      else if (pick < 12)   s = $urandom_range(gme_pkg::MAX_SIDE_DEF, SIDE_TOP);
      else if (pick < 25)   s = $urandom_range(9, 20);
      else                  s = $urandom_range(2, 8);
      write_side(s);

      // large images are not filled and get no whole-image walks until fully defined
      n    = cur_side * cur_side;
      full = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!written[i]) begin
          if (cur_side <= FILL_SIDE) push_item(gme_pkg::K_LOAD, i, $urandom_range(511));
          else full = 1'b0;
        end
      end

      // hold idling off for a long middle stretch
      gaps_on = !(item_count inside {[600:1000]});
      walks_left = !full ? 0 : (cur_side > 20) ? 2 : 12;
      if (cur_side <= 8 && $urandom_range(3) == 0) build_diagonal();
      len = $urandom_range(20, 80);
      repeat (len) random_item(walks_left);
      phase++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
